// ===== rtl/core/prd_pkg.sv =====
// shared types, constants and the code alphabet lookup for the palette run-length decoder
package prd_pkg;

  localparam int PALETTE_DEPTH = 82;
  localparam int MAX_PIXELS    = 1048576;
  localparam int ENTRY_W       = 7;
  localparam int PIX_W         = 21;
  localparam int COLOR_W       = 8;
  localparam int RGB_W         = 3 * COLOR_W;
  localparam int COUNT_W       = 4;
  localparam int CHAR_W        = 8;
  localparam int SIZE_W        = 7;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] LOWER_BASE = 8'd26;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_DECODE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_LOAD,
    CMD_START,
    CMD_DIGIT,
    CMD_CODE,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [ENTRY_W-1:0]   idx;
    logic [RGB_W-1:0]     rgb;
    logic [COUNT_W-1:0]   digit;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic               hit;
    logic [ENTRY_W-1:0] idx;
  } sym_t;

  function automatic sym_t sym_lookup(input logic [CHAR_W-1:0] ch);
    sym_t             s;
    logic [CHAR_W-1:0] d;
    s.hit = 1'b1;
    s.idx = '0;
    d     = '0;
    if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
      d     = ch - CHAR_UP_A;
      s.idx = d[ENTRY_W-1:0];
    end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z) begin
      d     = ch - CHAR_LO_A + LOWER_BASE;
      s.idx = d[ENTRY_W-1:0];
    end else begin
      unique case (ch)
        8'h2C: s.idx = 7'd52;
        8'h3C: s.idx = 7'd53;
        8'h2E: s.idx = 7'd54;
        8'h3E: s.idx = 7'd55;
        8'h2F: s.idx = 7'd56;
        8'h3F: s.idx = 7'd57;
        8'h3B: s.idx = 7'd58;
        8'h3A: s.idx = 7'd59;
        8'h27: s.idx = 7'd60;
        8'h5B: s.idx = 7'd61;
        8'h7B: s.idx = 7'd62;
        8'h5D: s.idx = 7'd63;
        8'h7D: s.idx = 7'd64;
        8'h7C: s.idx = 7'd65;
        8'h3D: s.idx = 7'd66;
        8'h2B: s.idx = 7'd67;
        8'h2D: s.idx = 7'd68;
        8'h5F: s.idx = 7'd69;
        8'h29: s.idx = 7'd70;
        8'h28: s.idx = 7'd71;
        8'h2A: s.idx = 7'd72;
        8'h26: s.idx = 7'd73;
        8'h5E: s.idx = 7'd74;
        8'h25: s.idx = 7'd75;
        8'h24: s.idx = 7'd76;
        8'h23: s.idx = 7'd77;
        8'h40: s.idx = 7'd78;
        8'h21: s.idx = 7'd79;
        8'h60: s.idx = 7'd80;
        8'h7E: s.idx = 7'd81;
        default: s.hit = 1'b0;
      endcase
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/palette_rle_pixel_decoder.sv =====
// top level: palette run-length pixel decoder with apb configuration
// path: a code beat passes the command queue, the run start and the pixel output register;
// its run then gives one pixel a cycle while the sink is ready; no command is popped meanwhile
// loads, new-image and digit beats give no result, but a digit after a held digit is an error
// the front accepts while the two-entry command queue has room
// reset: synchronous rst clears queue, run state and halt; registers go to 9 pixels, 1 entry
module palette_rle_pixel_decoder (
  input  logic                         clk,
  input  logic                         rst,
  // input beat channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic [prd_pkg::ENTRY_W-1:0]  entry_index,
  input  logic [prd_pkg::COLOR_W-1:0]  entry_red,
  input  logic [prd_pkg::COLOR_W-1:0]  entry_green,
  input  logic [prd_pkg::COLOR_W-1:0]  entry_blue,
  input  logic [prd_pkg::CHAR_W-1:0]   code_char,
  // pixel beat channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [prd_pkg::COLOR_W-1:0]  red,
  output logic [prd_pkg::COLOR_W-1:0]  green,
  output logic [prd_pkg::COLOR_W-1:0]  blue,
  output logic                         last_of_run,
  output logic                         image_done,
  output logic                         status,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import prd_pkg::*;

  localparam logic REG_PIXEL_TOTAL  = 1'b0;
  localparam logic REG_PALETTE_SIZE = 1'b1;

  logic [PIX_W-1:0]  pixel_total;
  logic [SIZE_W-1:0] palette_size;
  logic              cfg_write;
  logic              reg_sel;

  logic              push_valid;
  logic              push_ready;
  cmd_t              push_cmd;
  logic              pop_valid;
  logic              pop_ready;
  cmd_t              pop_cmd;

  // register select is the word address, byte offset bits are ignored
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_total  <= PIX_W'(9);
      palette_size <= SIZE_W'(1);
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_PIXEL_TOTAL:  pixel_total  <= pwdata[PIX_W-1:0];
        REG_PALETTE_SIZE: palette_size <= pwdata[SIZE_W-1:0];
        default:          pixel_total  <= pixel_total;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PIXEL_TOTAL:  prdata = {{(32-PIX_W){1'b0}}, pixel_total};
      REG_PALETTE_SIZE: prdata = {{(32-SIZE_W){1'b0}}, palette_size};
      default:          prdata = '0;
    endcase
  end

  // front: classify each input beat into a command
  prd_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .entry_index (entry_index),
    .entry_red   (entry_red),
    .entry_green (entry_green),
    .entry_blue  (entry_blue),
    .code_char   (code_char),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  // short queue so the front keeps taking beats while a run drains
  prd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // back: palette writes, halt and count state, one pixel per cycle while the sink is ready
  prd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_cmd      (pop_cmd),
    .pixel_total  (pixel_total),
    .palette_size (palette_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .last_of_run  (last_of_run),
    .image_done   (image_done),
    .status       (status)
  );

endmodule

// ===== rtl/core/prd_front.sv =====
// front end: classifies input beats into decoder commands
module prd_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic [prd_pkg::ENTRY_W-1:0]  entry_index,
  input  logic [prd_pkg::COLOR_W-1:0]  entry_red,
  input  logic [prd_pkg::COLOR_W-1:0]  entry_green,
  input  logic [prd_pkg::COLOR_W-1:0]  entry_blue,
  input  logic [prd_pkg::CHAR_W-1:0]   code_char,
  output logic                         push_valid,
  input  logic                         push_ready,
  output prd_pkg::cmd_t                push_cmd
);
  import prd_pkg::*;

  opcode_t           op;
  sym_t              sym;
  logic              is_digit;
  logic              keep;
  logic [CHAR_W-1:0] digit_val;

  assign op        = opcode_t'(opcode);
  assign sym       = sym_lookup(code_char);
  assign is_digit  = (code_char >= CHAR_ZERO) && (code_char <= CHAR_NINE);
  assign digit_val = code_char - CHAR_ZERO;

  always_comb begin
    push_cmd.kind  = CMD_BAD;
    push_cmd.idx   = entry_index;
    push_cmd.rgb   = {entry_red, entry_green, entry_blue};
    push_cmd.digit = digit_val[COUNT_W-1:0];
    keep           = 1'b1;
    unique case (op)
      OP_LOAD: begin
        push_cmd.kind = CMD_LOAD;
        // entries past the palette are dropped here
        keep = (entry_index < ENTRY_W'(PALETTE_DEPTH));
      end
      OP_START: push_cmd.kind = CMD_START;
      OP_DECODE: begin
        priority if (sym.hit) begin
          push_cmd.kind = CMD_CODE;
          push_cmd.idx  = sym.idx;
        end else if (is_digit) begin
          push_cmd.kind = CMD_DIGIT;
        end else begin
          push_cmd.kind = CMD_BAD;
        end
      end
      OP_NONE: keep = 1'b0;
      default: keep = 1'b0;
    endcase
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid && keep;

endmodule

// ===== rtl/core/prd_fifo.sv =====
// two-entry command queue between front and back
module prd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  prd_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output prd_pkg::cmd_t pop_cmd
);
  import prd_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/prd_back.sv =====
// back end: palette memory, run state and pixel output register
module prd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  prd_pkg::cmd_t                pop_cmd,
  input  logic [prd_pkg::PIX_W-1:0]    pixel_total,
  input  logic [prd_pkg::SIZE_W-1:0]   palette_size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [prd_pkg::COLOR_W-1:0]  red,
  output logic [prd_pkg::COLOR_W-1:0]  green,
  output logic [prd_pkg::COLOR_W-1:0]  blue,
  output logic                         last_of_run,
  output logic                         image_done,
  output logic                         status
);
  import prd_pkg::*;

  logic [RGB_W-1:0]   palette [PALETTE_DEPTH];
  logic [RGB_W-1:0]   rdata;

  back_state_t        state;
  back_state_t        state_next;
  logic [COUNT_W-1:0] pending_count;
  logic               count_pending;
  logic [PIX_W-1:0]   pixels_emitted;
  logic               halted;
  logic [COUNT_W-1:0] run_left;

  logic [PIX_W-1:0]   limit;
  logic [SIZE_W-1:0]  size_lim;
  logic [PIX_W-1:0]   remain;
  logic [PIX_W-1:0]   emitted_inc;
  logic [COUNT_W-1:0] run_raw;
  logic [COUNT_W-1:0] run;
  logic               complete;
  logic               active;
  logic               slot_free;
  logic               pop_fire;

  logic               do_write;
  logic               do_clear;
  logic               set_digit;
  logic               do_error;
  logic               start_run;
  logic               emit_px;

  assign limit       = (pixel_total > PIX_W'(MAX_PIXELS)) ? PIX_W'(MAX_PIXELS) : pixel_total;
  assign size_lim    = (palette_size > SIZE_W'(PALETTE_DEPTH)) ? SIZE_W'(PALETTE_DEPTH)
                                                              : palette_size;
  assign complete    = (pixels_emitted >= limit);
  assign active      = !halted && !complete;
  assign remain      = limit - pixels_emitted;
  assign emitted_inc = pixels_emitted + 1'b1;
  assign run_raw     = count_pending ? pending_count : COUNT_W'(1);
  assign run         = (remain < PIX_W'(run_raw)) ? remain[COUNT_W-1:0] : run_raw;
  assign slot_free   = !out_valid || out_ready;
  assign pop_fire    = pop_valid && pop_ready;

  // command decode and per-cycle actions
  always_comb begin
    pop_ready = 1'b0;
    do_write  = 1'b0;
    do_clear  = 1'b0;
    set_digit = 1'b0;
    do_error  = 1'b0;
    start_run = 1'b0;
    emit_px   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pop_ready = slot_free;
        if (pop_valid && slot_free) begin
          unique case (pop_cmd.kind)
            CMD_LOAD:  do_write = 1'b1;
            CMD_START: do_clear = 1'b1;
            CMD_DIGIT: begin
              if (active) begin
                if (count_pending) begin
                  do_error = 1'b1;
                end else begin
                  set_digit = 1'b1;
                end
              end
            end
            CMD_CODE: begin
              if (active) begin
                if (pop_cmd.idx >= size_lim) begin
                  do_error = 1'b1;
                end else begin
                  start_run = (run != '0);
                end
              end
            end
            CMD_BAD:   do_error = active;
            default:   do_error = 1'b0;
          endcase
        end
      end
      ST_EMIT: emit_px = slot_free;
      default: pop_ready = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start_run) state_next = ST_EMIT;
      ST_EMIT: if (emit_px && run_left == COUNT_W'(1)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      palette[pop_cmd.idx] <= pop_cmd.rgb;
    end
    if (start_run) begin
      rdata <= palette[pop_cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pending_count  <= '0;
      count_pending  <= 1'b0;
      pixels_emitted <= '0;
      halted         <= 1'b0;
      run_left       <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (do_clear) begin
        pixels_emitted <= '0;
        pending_count  <= '0;
        count_pending  <= 1'b0;
        halted         <= 1'b0;
      end
      if (set_digit) begin
        pending_count <= pop_cmd.digit;
        count_pending <= 1'b1;
      end
      if (do_error || start_run || (pop_fire && pop_cmd.kind == CMD_CODE && active)) begin
        pending_count <= '0;
        count_pending <= 1'b0;
      end
      if (do_error) begin
        halted <= 1'b1;
      end
      if (start_run) begin
        run_left <= run;
      end
      if (emit_px) begin
        run_left       <= run_left - 1'b1;
        pixels_emitted <= emitted_inc;
      end
      if (do_error || emit_px) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_error) begin
      {red, green, blue} <= '0;
      last_of_run        <= 1'b1;
      image_done         <= 1'b0;
      status             <= 1'b1;
    end else if (emit_px) begin
      {red, green, blue} <= rdata;
      last_of_run        <= (run_left == COUNT_W'(1));
      image_done         <= (emitted_inc == limit);
      status             <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/prd_checker.sv =====
// port-level checks for the palette run-length decoder and their bind
module prd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       last_of_run,
  input logic       image_done,
  input logic       status,
  input logic       pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(red))
    else $error("pixel beat dropped or changed while stalled");

  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last_of_run && !image_done &&
                            red == 8'd0 && green == 8'd0 && blue == 8'd0)
    else $error("error beat carries pixel data or wrong flags");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_done |-> last_of_run && !status)
    else $error("image end not on the last pixel of a run");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("configuration port stalled");

endmodule

bind palette_rle_pixel_decoder prd_checker u_prd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .red         (red),
  .green       (green),
  .blue        (blue),
  .last_of_run (last_of_run),
  .image_done  (image_done),
  .status      (status),
  .pready      (pready)
);

// ===== sim/testbench.sv =====
// self-checking testbench for the palette run-length pixel decoder
`timescale 1ns / 1ps

module testbench;
  import prd_pkg::*;

  // register map: one 32-bit word per register
  localparam logic [2:0] REG_PIXEL_TOTAL  = 3'd0;
  localparam logic [2:0] REG_PALETTE_SIZE = 3'd4;

  localparam int PHASES        = 6;   // register settings after the directed part
  localparam int ACTIONS       = 16;  // random actions per setting
  localparam int SETTLE_CYCLES = 14;  // room for the first pixel of a code and a run of nine after it
  localparam int STALL_LIMIT   = 2000;

  // one beat on the input channel
  typedef struct {
    opcode_t      op;
    logic [6:0]   entry;
    logic [23:0]  rgb;
    logic [7:0]   ch;
  } dec_cmd_t;

  // one beat on the pixel channel
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    logic       done;
    logic       err;
  } pixel_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [6:0]  entry_index;
  logic [7:0]  entry_red;
  logic [7:0]  entry_green;
  logic [7:0]  entry_blue;
  logic [7:0]  code_char;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_of_run;
  logic        image_done;
  logic        status;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  palette_rle_pixel_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .entry_index (entry_index),
    .entry_red   (entry_red),
    .entry_green (entry_green),
    .entry_blue  (entry_blue),
    .code_char   (code_char),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last_of_run (last_of_run),
    .image_done  (image_done),
    .status      (status),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // beats waiting to be driven, pixels waiting to arrive
  dec_cmd_t decoder_cmds[$];
  pixel_t   pending_pixels[$];

  // decoder shadow: palette, held digit, pixel count, halt, registers
  logic [23:0] pal_mem[PALETTE_DEPTH];
  int          held_count;
  bit          digit_held;
  int          emitted;
  bit          stopped;
  logic [20:0] cfg_total;
  logic [6:0]  cfg_size;

  // stimulus bookkeeping: entries that hold a color, so no code reads an empty one
  bit          entry_loaded[PALETTE_DEPTH];

  dec_cmd_t cur_cmd;
  pixel_t   head_pixel;
  bit       in_taken;
  int       src_gap;
  int       sink_gap;
  int       idle_pct;
  bit       calm;
  int       stall_cycles;
  int       fail_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // character for an alphabet slot: upper case, lower case, then punctuation
  function automatic logic [7:0] code_of(input int slot);
    string punct;
    punct = ",<.>/?;:'[{]}|=+-_)(*&^%$#@!\140~";
    if (slot < 26) return CHAR_UP_A + 8'(slot);
    if (slot < 52) return CHAR_LO_A + 8'(slot - 26);
    return punct[slot - 52];
  endfunction

  // alphabet slot of a character, -1 when it is no palette code
  function automatic int index_of(input logic [7:0] ch);
    int k;
    for (k = 0; k < PALETTE_DEPTH; k++)
      if (code_of(k) == ch) return k;
    return -1;
  endfunction

  function automatic int palette_limit();
    return (int'(cfg_size) < PALETTE_DEPTH) ? int'(cfg_size) : PALETTE_DEPTH;
  endfunction

  // work out the pixels that one accepted beat gives
  function automatic void decode_cmd(input dec_cmd_t c);
    int     limit;
    int     slot;
    int     run;
    int     k;
    pixel_t px;
    if (c.op == OP_LOAD) begin
      if (int'(c.entry) < PALETTE_DEPTH) pal_mem[c.entry] = c.rgb;
      return;
    end
    if (c.op == OP_START) begin
      emitted    = 0;
      held_count = 0;
      digit_held = 1'b0;
      stopped    = 1'b0;
      return;
    end
    if (c.op != OP_DECODE) return;
    limit = (int'(cfg_total) < MAX_PIXELS) ? int'(cfg_total) : MAX_PIXELS;
    // halted or image already complete: the code is dropped
    if (stopped || emitted >= limit) return;
    slot = index_of(c.ch);
    if (slot < 0 && !digit_held && c.ch >= CHAR_ZERO && c.ch <= CHAR_NINE) begin
      held_count = int'(c.ch[3:0]);
      digit_held = 1'b1;
      return;
    end
    if (slot < 0 || slot >= palette_limit()) begin
      // bad code: one zero pixel with the error flag, then halt
      held_count = 0;
      digit_held = 1'b0;
      stopped    = 1'b1;
      px.red     = 8'h00;
      px.green   = 8'h00;
      px.blue    = 8'h00;
      px.last    = 1'b1;
      px.done    = 1'b0;
      px.err     = 1'b1;
      pending_pixels.push_back(px);
      return;
    end
    run        = digit_held ? held_count : 1;
    held_count = 0;
    digit_held = 1'b0;
    // a run is cut where the image ends
    if (run > limit - emitted) run = limit - emitted;
    for (k = 0; k < run; k++) begin
      emitted++;
      px.red   = pal_mem[slot][23:16];
      px.green = pal_mem[slot][15:8];
      px.blue  = pal_mem[slot][7:0];
      px.last  = (k == run - 1);
      px.done  = (emitted == limit);
      px.err   = 1'b0;
      pending_pixels.push_back(px);
    end
  endfunction

  function automatic void push_cmd(input opcode_t op, input logic [6:0] entry,
                                   input logic [23:0] rgb, input logic [7:0] ch);
    dec_cmd_t c;
    c.op    = op;
    c.entry = entry;
    c.rgb   = rgb;
    c.ch    = ch;
    decoder_cmds.push_back(c);
  endfunction

  function automatic void push_load(input logic [6:0] entry, input logic [23:0] rgb);
    if (int'(entry) < PALETTE_DEPTH) entry_loaded[entry] = 1'b1;
    push_cmd(OP_LOAD, entry, rgb, 8'($urandom));
  endfunction

  // fields a beat does not use carry random bits
  function automatic void push_code(input logic [7:0] ch);
    push_cmd(OP_DECODE, 7'($urandom), 24'($urandom), ch);
  endfunction

  function automatic void push_start();
    push_cmd(OP_START, 7'($urandom), 24'($urandom), 8'($urandom));
  endfunction

  // a code for an entry in use that holds a color; entry 0 is always loaded
  function automatic logic [7:0] loaded_code();
    int slot;
    slot = $urandom_range(0, palette_limit() - 1);
    while (!entry_loaded[slot]) slot = (slot + 1) % palette_limit();
    return code_of(slot);
  endfunction

  // any byte, except a code that would read an empty entry
  function automatic logic [7:0] noise_byte();
    logic [7:0] ch;
    int         slot;
    ch   = 8'($urandom_range(0, 255));
    slot = index_of(ch);
    if (slot >= 0 && slot < palette_limit() && !entry_loaded[slot]) ch = loaded_code();
    return ch;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // register write, then read back; the shadow takes the value at the write
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == REG_PIXEL_TOTAL) cfg_total = value[20:0];
    else cfg_size = value[6:0];
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field(addr == REG_PIXEL_TOTAL ? "pixel_total" : "palette_size", value, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // hold off until every queued beat is in and every pixel is out
  task automatic wait_drained();
    do @(posedge clk);
    while (decoder_cmds.size() != 0 || in_valid || pending_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // input driver: a new beat only once the previous one went in
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (decoder_cmds.size() != 0) begin
        cur_cmd = decoder_cmds.pop_front();
        opcode      <= cur_cmd.op;
        entry_index <= cur_cmd.entry;
        entry_red   <= cur_cmd.rgb[23:16];
        entry_green <= cur_cmd.rgb[15:8];
        entry_blue  <= cur_cmd.rgb[7:0];
        code_char   <= cur_cmd.ch;
        in_valid    <= 1'b1;
        // idle burst that follows this beat
        if (!calm && $urandom_range(0, 99) < idle_pct) src_gap = $urandom_range(1, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // pixel sink: ready drops in random bursts
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < idle_pct / 2) sink_gap = $urandom_range(1, 11);
    end
  end

  // input acceptance feeds the shadow decoder
  always @(posedge clk) begin
    in_taken = !rst && in_valid && in_ready;
    if (in_taken) decode_cmd(cur_cmd);
  end

  // pixel monitor and stall watchdog
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel beat with no pixel expected");
        fail_count++;
      end else begin
        head_pixel = pending_pixels.pop_front();
        check_field("red", head_pixel.red, red);
        check_field("green", head_pixel.green, green);
        check_field("blue", head_pixel.blue, blue);
        check_field("last_of_run", head_pixel.last, last_of_run);
        check_field("image_done", head_pixel.done, image_done);
        check_field("status", head_pixel.err, status);
      end
    end
    if (rst || psel || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int phase;
    int act;
    int roll;
    int run;
    int digit;
    int gen_pixels;
    int cfg_pixels;
    int cfg_entries;

    // every input known from time zero
    rst         = 1'b1;
    in_valid    = 1'b0;
    opcode      = OP_NONE;
    entry_index = '0;
    entry_red   = '0;
    entry_green = '0;
    entry_blue  = '0;
    code_char   = '0;
    out_ready   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_taken    = 1'b0;
    src_gap     = 0;
    sink_gap    = 0;
    idle_pct    = 30;
    calm        = 1'b0;
    stall_cycles = 0;
    fail_count  = 0;
    // shadow state after reset: 9 pixels, one palette entry
    held_count  = 0;
    digit_held  = 1'b0;
    emitted     = 0;
    stopped     = 1'b0;
    cfg_total   = 21'd9;
    cfg_size    = 7'd1;
    for (int k = 0; k < PALETTE_DEPTH; k++) begin
      pal_mem[k]      = '0;
      entry_loaded[k] = 1'b0;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset register values
    push_load(7'd0, 24'hFF00A5);
    push_load(7'd127, 24'h5AFF00);          // load past the palette, ignored
    push_load(7'd82, 24'h123456);           // first index past the palette, ignored
    push_load(7'd81, 24'h00FF5A);
    push_cmd(OP_NONE, 7'h7F, 24'hFFFFFF, 8'hFF);  // spare opcode, ignored
    push_code(code_of(0));                  // single pixel
    push_code(CHAR_NINE);                   // run of nine cut to the eight left
    push_code(code_of(0));
    push_code(code_of(0));                  // image complete, ignored
    push_start();
    push_code(CHAR_ZERO);                   // zero count gives nothing
    push_code(code_of(0));
    push_code(code_of(1));                  // code past the palette size: error, halt
    push_code(code_of(0));                  // halted, ignored
    push_start();
    push_code(CHAR_ZERO + 8'd5);            // digit after digit: error
    push_code(CHAR_NINE);
    push_start();
    push_code(8'hFF);                       // byte outside the alphabet
    push_start();
    push_code(CHAR_ZERO + 8'd3);            // run of three
    push_code(code_of(0));
    push_code(8'h00);
    wait_drained();

    // random part over several register settings, extremes first
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          cfg_pixels  = MAX_PIXELS;
          cfg_entries = PALETTE_DEPTH;
        end
        1: begin
          cfg_pixels  = 9;
          cfg_entries = PALETTE_DEPTH;
        end
        2: begin
          cfg_pixels  = 13;
          cfg_entries = 1;
        end
        3: begin
          cfg_pixels  = $urandom_range(9, 64);
          cfg_entries = $urandom_range(2, 81);
        end
        4: begin
          cfg_pixels  = 40;
          cfg_entries = 26;
        end
        default: begin
          cfg_pixels  = $urandom_range(9, 30);
          cfg_entries = $urandom_range(1, PALETTE_DEPTH);
        end
      endcase
      // no idling, light idling, heavy idling; none at all in the last setting
      idle_pct = (phase % 3) * 25;
      if (phase == PHASES - 1) calm = 1'b1;
      write_reg(REG_PIXEL_TOTAL, 32'(cfg_pixels));
      write_reg(REG_PALETTE_SIZE, 32'(cfg_entries));

      push_load(7'd0, 24'($urandom));
      push_load(7'(palette_limit() - 1), 24'($urandom));
      repeat ($urandom_range(2, 6)) push_load(7'($urandom_range(0, 127)), 24'($urandom));
      push_start();
      gen_pixels = 0;

      for (act = 0; act < ACTIONS; act++) begin
        // one pause mid-setting until every pixel is out
        if (phase == 2 && act == ACTIONS / 2) wait_drained();
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          // well-formed: optional count digit, then a loaded code
          run = 1;
          if ($urandom_range(0, 1) == 1) begin
            digit = $urandom_range(0, 9);
            push_code(CHAR_ZERO + 8'(digit));
            run = digit;
          end
          push_code(loaded_code());
          gen_pixels += run;
        end else if (roll < 63) begin
          push_load(7'($urandom_range(0, 127)), 24'($urandom));
        end else if (roll < 70) begin
          push_start();
          gen_pixels = 0;
        end else if (roll < 78) begin
          push_code(noise_byte());
        end else if (roll < 84) begin
          if (palette_limit() < PALETTE_DEPTH)
            push_code(code_of($urandom_range(palette_limit(), PALETTE_DEPTH - 1)));
          else
            push_code(noise_byte());
        end else if (roll < 90) begin
          push_code(CHAR_ZERO + 8'($urandom_range(0, 9)));
          push_code(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end else begin
          push_cmd(OP_NONE, 7'($urandom), 24'($urandom), 8'($urandom));
        end
        // after a likely error, usually begin a fresh image
        if (roll >= 70 && roll < 90 && $urandom_range(0, 3) != 0) begin
          push_start();
          gen_pixels = 0;
        end
        // the image has probably filled up
        if (gen_pixels >= cfg_pixels) begin
          push_start();
          gen_pixels = 0;
        end
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
